>>> src/mcep_pkg.sv
// shared types and constants for the midi control event parser
// no dependencies; front end, queue, back end, core and testbench import this package
`timescale 1ns / 1ps

package mcep_pkg;

   // window sizes and mode scaling
   localparam int TRIGGER_COUNT    = 16;
   localparam int CONTROLLER_COUNT = 16;
   localparam int MODE_COUNT       = 8;

   // event kind codes
   localparam logic [1:0] KIND_TRIGGER = 2'd0;
   localparam logic [1:0] KIND_CTRL    = 2'd1;
   localparam logic [1:0] KIND_MODE    = 2'd2;
   localparam logic [1:0] KIND_RESET   = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_TRIGGER_BASE = 2'd0;
   localparam logic [1:0] CSR_CTRL_BASE    = 2'd1;
   localparam logic [1:0] CSR_MODE_CTRL    = 2'd2;

   // classified event handed from the front end to the back end
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] slot;
      logic [6:0] data;
   } mcep_event_type;

endpackage

>>> src/mcep_ifs.sv
// channel interfaces: midi byte input, event output, csr write
// no dependencies
`timescale 1ns / 1ps

interface mcep_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;

   modport source (output valid, output midi_byte, input ready);
   modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mcep_event_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  event_kind;
   logic        [3:0]  slot_index;
   logic signed [15:0] control_level;
   logic        [6:0]  raw_data;
   logic        [2:0]  display_mode;

   modport source (output valid, output event_kind, output slot_index,
                   output control_level, output raw_data, output display_mode,
                   input ready);
   modport sink   (input valid, input event_kind, input slot_index,
                   input control_level, input raw_data, input display_mode,
                   output ready);
endinterface

interface mcep_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/mcep_front.sv
// front end: csr registers, running status parse, event classification
// depends on mcep_pkg and mcep_ifs
`timescale 1ns / 1ps

module mcep_front (
   input  logic                    clock,
   input  logic                    reset,
   mcep_byte_if.sink               req_chan,
   mcep_csr_if.sink                csr_chan,
   input  logic                    q_full,
   output logic                    push,
   output mcep_pkg::mcep_event_type push_data
);
   import mcep_pkg::*;

   localparam logic [1:0] PHASE_CLEAR  = 2'd0;
   localparam logic [1:0] PHASE_STATUS = 2'd1;
   localparam logic [1:0] PHASE_DATA1  = 2'd2;
   localparam logic [1:0] PHASE_SYSEX  = 2'd3;

   localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
   localparam logic [7:0] BYTE_SYS_RESET   = 8'hFF;
   localparam logic [3:0] TYPE_NOTE_ON     = 4'h9;
   localparam logic [3:0] TYPE_CTRL        = 4'hB;
   localparam logic [3:0] TYPE_PROGRAM     = 4'hC;
   localparam logic [3:0] TYPE_AFTERTOUCH  = 4'hD;
   localparam logic [3:0] TYPE_SYSTEM      = 4'hF;

   logic [6:0] trig_base_ff, trig_base_in;
   logic [6:0] ctrl_base_ff, ctrl_base_in;
   logic [6:0] mode_num_ff,  mode_num_in;
   logic [1:0] phase_ff,     phase_in;
   logic [7:0] status_ff,    status_in;
   logic [6:0] first_ff,     first_in;

   logic       accept;
   logic [7:0] b;
   logic [3:0] msg_type;
   logic [8:0] trig_hi;
   logic [8:0] ctrl_hi;
   logic       trig_hit;
   logic       ctrl_hit;
   logic [6:0] trig_off;
   logic [6:0] ctrl_off;

   assign req_chan.ready = !q_full;
   assign csr_chan.ready = 1'b1;
   assign accept   = req_chan.valid && req_chan.ready;
   assign b        = req_chan.midi_byte;
   assign msg_type = status_ff[7:4];

   // windows: 9 bits so base plus count never wraps
   assign trig_hi  = {2'b00, trig_base_ff} + 9'(TRIGGER_COUNT);
   assign ctrl_hi  = {2'b00, ctrl_base_ff} + 9'(CONTROLLER_COUNT);
   assign trig_hit = (first_ff >= trig_base_ff) && ({2'b00, first_ff} < trig_hi);
   assign ctrl_hit = (first_ff >= ctrl_base_ff) && ({2'b00, first_ff} < ctrl_hi);
   assign trig_off = first_ff - trig_base_ff;
   assign ctrl_off = first_ff - ctrl_base_ff;

   always_comb begin
      trig_base_in = trig_base_ff;
      ctrl_base_in = ctrl_base_ff;
      mode_num_in  = mode_num_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_TRIGGER_BASE: trig_base_in = csr_chan.data;
            CSR_CTRL_BASE:    ctrl_base_in = csr_chan.data;
            CSR_MODE_CTRL:    mode_num_in  = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      first_in  = first_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         if (b[7]) begin
            if (b inside {[8'hF8:8'hFF]}) begin
               // realtime passes by, system reset clears and reports
               if (b == BYTE_SYS_RESET) begin
                  phase_in       = PHASE_CLEAR;
                  push           = 1'b1;
                  push_data.kind = KIND_RESET;
               end
            end else if (b[7:4] == TYPE_SYSTEM) begin
               phase_in = (b == BYTE_SYSEX_START) ? PHASE_SYSEX : PHASE_CLEAR;
            end else begin
               phase_in  = PHASE_STATUS;
               status_in = b;
            end
         end else begin
            case (phase_ff)
               PHASE_STATUS: begin
                  first_in = b[6:0];
                  phase_in = (msg_type inside {TYPE_PROGRAM, TYPE_AFTERTOUCH}) ?
                             PHASE_STATUS : PHASE_DATA1;
               end
               PHASE_DATA1: begin
                  phase_in       = PHASE_STATUS;
                  push_data.data = b[6:0];
                  if (msg_type == TYPE_NOTE_ON) begin
                     if (b != 8'h00 && trig_hit) begin
                        push           = 1'b1;
                        push_data.kind = KIND_TRIGGER;
                        push_data.slot = trig_off[3:0];
                     end
                  end else if (msg_type == TYPE_CTRL) begin
                     if (ctrl_hit) begin
                        push           = 1'b1;
                        push_data.kind = KIND_CTRL;
                        push_data.slot = ctrl_off[3:0];
                     end else if (first_ff == mode_num_ff) begin
                        push           = 1'b1;
                        push_data.kind = KIND_MODE;
                     end
                  end
               end
               default: ; // clear or sysex: data ignored
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_base_ff <= 7'd60;
         ctrl_base_ff <= 7'd70;
         mode_num_ff  <= 7'd16;
         phase_ff     <= PHASE_CLEAR;
         status_ff    <= '0;
         first_ff     <= '0;
      end else begin
         trig_base_ff <= trig_base_in;
         ctrl_base_ff <= ctrl_base_in;
         mode_num_ff  <= mode_num_in;
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         first_ff     <= first_in;
      end
   end

   a_sys_reset_event: assert property (@(posedge clock) disable iff (reset)
      (accept && b == BYTE_SYS_RESET) |-> (push && push_data.kind == KIND_RESET))
      else $error("system reset byte did not produce a reset event");

   a_sysex_enter: assert property (@(posedge clock) disable iff (reset)
      (accept && b == BYTE_SYSEX_START) |=> (phase_ff == PHASE_SYSEX))
      else $error("sysex start did not enter sysex phase");

endmodule

>>> src/mcep_queue.sv
// small fifo of classified events between front and back end
// depends on mcep_pkg
`timescale 1ns / 1ps

module mcep_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mcep_pkg::mcep_event_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output mcep_pkg::mcep_event_type pop_data
);
   import mcep_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mcep_event_type mem [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff,  count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

>>> src/mcep_back.sv
// back end: level and mode scaling, registered result output
// depends on mcep_pkg and mcep_ifs
`timescale 1ns / 1ps

module mcep_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  mcep_pkg::mcep_event_type q_data,
   output logic                     pop,
   mcep_event_if.source             rsp_chan
);
   import mcep_pkg::*;

   logic               valid_ff, valid_in;
   logic        [1:0]  kind_ff;
   logic        [3:0]  slot_ff;
   logic signed [15:0] level_ff;
   logic        [6:0]  raw_ff;
   logic        [2:0]  mode_ff;

   logic        [6:0]  v;
   logic        [6:0]  mag_x;
   logic        [15:0] mag;
   logic signed [15:0] level;
   logic        [13:0] mode_prod;

   assign v = q_data.data;

   // (2v-127)*32767/127 = x*258 + x/127 in magnitude, x/127 only 1 at full scale
   assign mag_x = v[6] ? 7'({v, 1'b0} - 8'd127) : 7'(8'd127 - {v, 1'b0});
   assign mag   = {1'b0, mag_x, 8'h00} + {8'h00, mag_x, 1'b0}
                + {15'd0, (mag_x == 7'd127)};
   assign level = v[6] ? signed'(mag) : -signed'(mag);

   assign mode_prod = {7'd0, v} * 14'(MODE_COUNT);

   assign pop      = q_valid && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= q_data.kind;
         slot_ff  <= q_data.slot;
         raw_ff   <= (q_data.kind == KIND_RESET) ? 7'd0 : v;
         level_ff <= (q_data.kind == KIND_CTRL) ? level : 16'sd0;
         mode_ff  <= (q_data.kind == KIND_MODE) ? mode_prod[9:7] : 3'd0;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.event_kind    = kind_ff;
   assign rsp_chan.slot_index    = slot_ff;
   assign rsp_chan.control_level = level_ff;
   assign rsp_chan.raw_data      = raw_ff;
   assign rsp_chan.display_mode  = mode_ff;

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped event not presented");

endmodule

>>> src/midi_control_event_parser_core.sv
// midi control event parser core: an event passes from the byte transaction through the queue
// and then the output register before its event transaction
// throughput one byte per cycle while the queue is not full; the queue absorbs output stalls
// an event stalled at the output holds while up to QUEUE_DEPTH more events queue up
// reset clears parse phase, held status and first data byte, restores csr defaults 60/70/16
// and empties the queue; csr writes are always accepted
`timescale 1ns / 1ps

module midi_control_event_parser_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   mcep_byte_if.sink    req_chan,
   mcep_event_if.source rsp_chan,
   mcep_csr_if.sink     csr_chan
);
   import mcep_pkg::*;

   // front end to queue
   logic           push;
   mcep_event_type push_data;
   logic           q_full;

   // queue to back end
   logic           pop;
   logic           q_valid;
   mcep_event_type q_data;

   // parser: takes one byte per transaction, tracks running status and
   // classifies complete messages into trigger, controller, mode or reset
   mcep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // decouples parsing from output backpressure
   mcep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   // scaling of controller level and display mode, then the output register
   mcep_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> dv/tb_midi_control_event_parser_core.sv
// self-checking testbench for midi_control_event_parser_core: random and directed byte streams
// depends on mcep_pkg, mcep_ifs and the parser core rtl
`timescale 1ns / 1ps

module tb_midi_control_event_parser_core;
   import mcep_pkg::*;

   // midi status codes used to build byte streams
   localparam logic [7:0] MIDI_NOTE_OFF      = 8'h80;
   localparam logic [7:0] MIDI_NOTE_ON       = 8'h90;
   localparam logic [7:0] MIDI_POLY_PRESSURE = 8'hA0;
   localparam logic [7:0] MIDI_CTRL_CHANGE   = 8'hB0;
   localparam logic [7:0] MIDI_PROGRAM       = 8'hC0;
   localparam logic [7:0] MIDI_CHAN_PRESSURE = 8'hD0;
   localparam logic [7:0] MIDI_PITCH_BEND    = 8'hE0;
   localparam logic [7:0] MIDI_SYSEX_START   = 8'hF0;
   localparam logic [7:0] MIDI_SONG_POS      = 8'hF2;
   localparam logic [7:0] MIDI_COMMON_FIRST  = 8'hF1;
   localparam logic [7:0] MIDI_COMMON_LAST   = 8'hF6;
   localparam logic [7:0] MIDI_SYSEX_END     = 8'hF7;
   localparam logic [7:0] MIDI_TIMING_CLOCK  = 8'hF8;
   localparam logic [7:0] MIDI_ACTIVE_SENSE  = 8'hFE;
   localparam logic [7:0] MIDI_SYSTEM_RESET  = 8'hFF;
   localparam logic [7:0] STATUS_TYPE_MASK   = 8'hF0;
   localparam logic [7:0] REALTIME_MASK      = 8'hF8;

   // register index that the block has no register for
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [1:0] {
      PHASE_CLEAR  = 2'd0,
      PHASE_STATUS = 2'd1,
      PHASE_DATA1  = 2'd2,
      PHASE_SYSEX  = 2'd3
   } midi_phase_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         slot;
      logic signed [15:0] level;
      logic [6:0]         raw;
      logic [2:0]         mode;
   } midi_event_type;

   logic clock;
   logic reset;

   mcep_byte_if  req_if ();
   mcep_event_if rsp_if ();
   mcep_csr_if   csr_if ();

   midi_control_event_parser_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // parser state mirrored by the predictor
   midi_phase_type parse_phase;
   logic [7:0]  held_status;
   logic [6:0]  first_data;
   int          cfg_trig_base;
   int          cfg_ctrl_base;
   int          cfg_mode_ctrl;

   logic [7:0]  pending_bytes[$];
   midi_event_type expected_events[$];

   int  bytes_queued;
   int  bytes_accepted;
   int  random_count;
   int  error_count;
   int  cycle_count;
   int  req_gap_left;
   int  rsp_stall_left;
   int  hold_left;
   int  holds_done;
   bit  req_idle_on;
   bit  rsp_idle_on;
   bit  running_ok;
   logic [7:0] last_status;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap lengths: mostly none or short, now and then a long one
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 50) return 0;
      if (r < 80) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // predictor: advances the parse state by one byte and queues the event it yields
   task automatic track_midi_byte(input logic [7:0] b);
      midi_event_type ev;
      logic [7:0]  status_kind;
      int          d1;
      int          v;
      ev = '0;
      d1 = first_data;
      v = b[6:0];
      status_kind = held_status & STATUS_TYPE_MASK;
      if (b[7]) begin
         if ((b & REALTIME_MASK) == REALTIME_MASK) begin
            // realtime passes by, only system reset acts
            if (b == MIDI_SYSTEM_RESET) begin
               parse_phase = PHASE_CLEAR;
               ev.kind = KIND_RESET;
               expected_events.push_back(ev);
            end
         end else if ((b & STATUS_TYPE_MASK) == STATUS_TYPE_MASK) begin
            // system common: held status survives, phase does not
            parse_phase = (b == MIDI_SYSEX_START) ? PHASE_SYSEX : PHASE_CLEAR;
         end else begin
            parse_phase = PHASE_STATUS;
            held_status = b;
         end
      end else if (parse_phase == PHASE_STATUS) begin
         first_data = b[6:0];
         if (status_kind == MIDI_PROGRAM || status_kind == MIDI_CHAN_PRESSURE)
            parse_phase = PHASE_STATUS;
         else
            parse_phase = PHASE_DATA1;
      end else if (parse_phase == PHASE_DATA1) begin
         parse_phase = PHASE_STATUS;
         ev.raw = b[6:0];
         if (status_kind == MIDI_NOTE_ON) begin
            if (v != 0 && d1 >= cfg_trig_base && d1 < cfg_trig_base + TRIGGER_COUNT) begin
               ev.kind = KIND_TRIGGER;
               ev.slot = 4'(d1 - cfg_trig_base);
               expected_events.push_back(ev);
            end
         end else if (status_kind == MIDI_CTRL_CHANGE) begin
            // controller window takes priority over the mode controller
            if (d1 >= cfg_ctrl_base && d1 < cfg_ctrl_base + CONTROLLER_COUNT) begin
               ev.kind = KIND_CTRL;
               ev.slot = 4'(d1 - cfg_ctrl_base);
               ev.level = 16'(((2 * v - 127) * 32767) / 127);
               expected_events.push_back(ev);
            end else if (d1 == cfg_mode_ctrl) begin
               ev.kind = KIND_MODE;
               ev.mode = 3'((v * MODE_COUNT) / 128);
               expected_events.push_back(ev);
            end
         end
      end
      // data byte while clear or inside sysex: nothing happens
   endtask

   task automatic check_event();
      midi_event_type want;
      if (expected_events.size() == 0) begin
         report_mismatch($sformatf("event kind %0d with nothing expected", rsp_if.event_kind));
         return;
      end
      want = expected_events.pop_front();
      if (rsp_if.event_kind !== want.kind)
         report_mismatch($sformatf("event_kind %0d, want %0d", rsp_if.event_kind, want.kind));
      if (rsp_if.slot_index !== want.slot)
         report_mismatch($sformatf("slot_index %0d, want %0d", rsp_if.slot_index, want.slot));
      if (rsp_if.control_level !== want.level)
         report_mismatch($sformatf("control_level %0d, want %0d",
                                   rsp_if.control_level, want.level));
      if (rsp_if.raw_data !== want.raw)
         report_mismatch($sformatf("raw_data %0d, want %0d", rsp_if.raw_data, want.raw));
      if (rsp_if.display_mode !== want.mode)
         report_mismatch($sformatf("display_mode %0d, want %0d",
                                   rsp_if.display_mode, want.mode));
   endtask

   // byte driver: offers the next pending byte, with random gaps between transactions
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.midi_byte <= '0;
         req_gap_left <= 0;
         bytes_accepted <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            track_midi_byte(req_if.midi_byte);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap_left != 0) begin
               req_if.valid <= 1'b0;
               req_gap_left <= req_gap_left - 1;
            end else if (pending_bytes.size() != 0) begin
               req_if.valid <= 1'b1;
               req_if.midi_byte <= pending_bytes.pop_front();
               req_gap_left <= pick_gap(req_idle_on);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // event monitor: checks each event transaction, stalls ready at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_event();
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
         end else if (rsp_stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_stall_left <= pick_gap(rsp_idle_on);
         end
      end
   end

   // long receiver hold-off, twice per run, so the event queue fills and input stalls
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && bytes_accepted >= 200 + holds_done * 900) begin
         hold_left <= 400;
         holds_done <= holds_done + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // stream byte, sometimes preceded by a realtime byte that must not disturb parsing
   task automatic push_item(input logic [7:0] b);
      if ($urandom_range(0, 99) < 4)
         queue_byte(8'($urandom_range(MIDI_TIMING_CLOCK, MIDI_ACTIVE_SENSE)));
      queue_byte(b);
      random_count++;
   endtask

   // status byte, left out half the time when running status allows it
   task automatic push_status(input logic [7:0] s);
      if (!(running_ok && s == last_status && $urandom_range(0, 1) == 1))
         push_item(s);
      last_status = s;
      running_ok = 1'b1;
   endtask

   function automatic logic [7:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'h7F;
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic logic [7:0] pick_note();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return {1'b0, 7'(cfg_trig_base + $urandom_range(0, TRIGGER_COUNT - 1))};
      if (r < 75) return {1'b0, 7'(cfg_trig_base - 1)};
      if (r < 85) return {1'b0, 7'(cfg_trig_base + TRIGGER_COUNT)};
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic logic [7:0] pick_controller();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return {1'b0, 7'(cfg_ctrl_base + $urandom_range(0, CONTROLLER_COUNT - 1))};
      if (r < 70) return {1'b0, 7'(cfg_mode_ctrl)};
      if (r < 75) return {1'b0, 7'(cfg_ctrl_base - 1)};
      if (r < 80) return {1'b0, 7'(cfg_ctrl_base + CONTROLLER_COUNT)};
      return 8'($urandom_range(0, 127));
   endfunction

   // one message: mostly well-formed channel traffic, the rest system bytes and noise
   task automatic push_random_message();
      int         sel;
      int         n;
      logic [3:0] chan;
      logic [7:0] kind_byte;
      sel = $urandom_range(0, 99);
      chan = 4'($urandom_range(0, 15));
      if (sel < 30) begin
         push_status(MIDI_NOTE_ON | chan);
         push_item(pick_note());
         push_item(($urandom_range(0, 99) < 15) ? 8'h00 : pick_value());
      end else if (sel < 60) begin
         push_status(MIDI_CTRL_CHANGE | chan);
         push_item(pick_controller());
         push_item(pick_value());
      end else if (sel < 68) begin
         push_status(($urandom_range(0, 1) == 1 ? MIDI_PROGRAM : MIDI_CHAN_PRESSURE) | chan);
         push_item(pick_value());
         if ($urandom_range(0, 99) < 40)
            push_item(pick_value());
      end else if (sel < 76) begin
         case ($urandom_range(0, 2))
            0:       kind_byte = MIDI_NOTE_OFF;
            1:       kind_byte = MIDI_POLY_PRESSURE;
            default: kind_byte = MIDI_PITCH_BEND;
         endcase
         push_status(kind_byte | chan);
         push_item(pick_note());
         push_item(pick_value());
      end else if (sel < 82) begin
         // sysex body, sometimes cut short by the next status
         push_item(MIDI_SYSEX_START);
         n = $urandom_range(0, 5);
         repeat (n) push_item(pick_value());
         if ($urandom_range(0, 99) < 80)
            push_item(MIDI_SYSEX_END);
         running_ok = 1'b0;
      end else if (sel < 86) begin
         push_item(8'($urandom_range(MIDI_COMMON_FIRST, MIDI_COMMON_LAST)));
         n = $urandom_range(0, 2);
         repeat (n) push_item(pick_value());
         running_ok = 1'b0;
      end else if (sel < 90) begin
         push_item(MIDI_SYSTEM_RESET);
         running_ok = 1'b0;
      end else if (sel < 95) begin
         // partial message, dropped by whatever status comes next
         push_status({1'b1, 3'($urandom_range(0, 6)), chan});
         push_item(pick_controller());
      end else begin
         push_item(8'($urandom_range(0, 255)));
         running_ok = 1'b0;
      end
   endtask

   task automatic run_random(input int count);
      random_count = 0;
      while (random_count < count)
         push_random_message();
   endtask

   // all bytes taken, all events back, then a settle wait for bytes that yield nothing
   task automatic wait_idle();
      while (!(bytes_accepted == bytes_queued && expected_events.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_csr(input logic [1:0] idx, input int value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= 7'(value);
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_TRIGGER_BASE: cfg_trig_base = value & 127;
         CSR_CTRL_BASE:    cfg_ctrl_base = value & 127;
         CSR_MODE_CTRL:    cfg_mode_ctrl = value & 127;
         default: ;
      endcase
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_windows(input int trig, input int ctrl, input int mode);
      program_csr(CSR_TRIGGER_BASE, trig);
      program_csr(CSR_CTRL_BASE, ctrl);
      program_csr(CSR_MODE_CTRL, mode);
   endtask

   initial begin
      // directed stream under reset defaults (trigger 60, controller 70, mode cc 16)
      logic [7:0] directed_bytes[] = '{
         MIDI_SYSTEM_RESET,                       // reset event
         8'h00,                                   // data while clear, ignored
         MIDI_NOTE_ON, 8'h3C, 8'h7F,              // trigger slot 0
         8'h4B, 8'h01,                            // running status, trigger slot 15
         8'h3C, 8'h00,                            // velocity zero, no event
         MIDI_CTRL_CHANGE, 8'h46, 8'h00,          // controller slot 0, lowest level
         8'h55, 8'h7F,                            // controller slot 15, highest level
         8'h10, 8'h40,                            // display mode 4
         MIDI_PROGRAM | 8'h03, 8'h05,             // program change, no event
         MIDI_SYSEX_START, 8'h3C, MIDI_SYSEX_END, // sysex body skipped
         8'h22,                                   // data after sysex end, ignored
         MIDI_SONG_POS, 8'h30,                    // system common clears phase
         MIDI_NOTE_ON, 8'h3C,                     // partial note-on, interrupted
         MIDI_CTRL_CHANGE, 8'h46, 8'h40,          // controller slot 0
         MIDI_ACTIVE_SENSE                        // realtime, no effect
      };

      reset = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      parse_phase = PHASE_CLEAR;
      held_status = '0;
      first_data = '0;
      cfg_trig_base = 60;
      cfg_ctrl_base = 70;
      cfg_mode_ctrl = 16;
      bytes_queued = 0;
      error_count = 0;
      running_ok = 1'b0;
      last_status = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);
      run_random(320);
      wait_idle();

      // lowest windows, mode controller at the top; spare index must be ignored
      program_windows(0, 0, 127);
      program_csr(CSR_SPARE_INDEX, $urandom_range(0, 127));
      req_idle_on = 1'b0;
      run_random(320);
      wait_idle();

      // windows starting at 127 reach past the top of the note range
      program_windows(127, 127, 0);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      run_random(320);
      wait_idle();

      // mode controller inside the controller window, controller wins
      program_windows(120, 112, 120);
      rsp_idle_on = 1'b1;
      run_random(320);
      wait_idle();

      program_windows(5, 10, 16);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(330);
      wait_idle();

      program_windows($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      run_random(340);
      wait_idle();

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
src/mcep_pkg.sv
src/mcep_ifs.sv
src/mcep_front.sv
src/mcep_queue.sv
src/mcep_back.sv
src/midi_control_event_parser_core.sv
dv/tb_midi_control_event_parser_core.sv
